@@ src/tds_pkg.sv @@
// Shared types and constants of the tick driven task scheduler.
`default_nettype none
package tds_pkg;

  localparam int MAX_TASKS = 16;
  localparam int SLOT_W    = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  typedef enum logic [2:0] {
    ST_FREE, ST_READY, ST_RUN, ST_IO, ST_DONE
  } status_t;

  localparam logic [2:0] MODE_FCFS   = 3'd0;
  localparam logic [2:0] MODE_SJF    = 3'd1;
  localparam logic [2:0] MODE_SJF_P  = 3'd2;
  localparam logic [2:0] MODE_PRIO   = 3'd3;
  localparam logic [2:0] MODE_PRIO_P = 3'd4;
  localparam logic [2:0] MODE_RR     = 3'd5;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_FINISHED = 3'd1;
  localparam logic [2:0] EV_TO_IO    = 3'd2;
  localparam logic [2:0] EV_PREEMPT  = 3'd3;
  localparam logic [2:0] EV_EXPIRED  = 3'd4;
  localparam logic [2:0] EV_IDLE_END = 3'd5;

  localparam logic REQ_ARRIVE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  localparam logic CFG_MODE    = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_POST, S_IOSCAN, S_DFIFO, S_RREXP,
    S_MINSCAN, S_DPICK, S_FIN, S_OUT
  } state_t;

  typedef struct packed {
    logic [7:0]  left_run;
    logic [7:0]  burst;
    logic [7:0]  prio;
    logic [7:0]  pt_a;
    logic [7:0]  len_a;
    logic [7:0]  pt_b;
    logic [7:0]  len_b;
    logic [7:0]  left_io;
    logic [15:0] wait_t;
    logic [15:0] arrive;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

endpackage
`default_nettype wire

@@ src/tds_ram.sv @@
// Generic simple dual port RAM with registered read.
`default_nettype none
module tds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/tick_driven_task_scheduler.sv @@
// Tick driven task scheduler: slot RAM walk, list handling and dispatch.
// Arrive transaction: taken in S_IDLE, no result.
// Tick transaction: slot RAM walk over all slots, I/O list scan, then a ready list minimum scan and
// dispatch in SJF/priority modes, or FIFO dispatch (plus quantum check in RR) in FCFS/RR modes;
// then the finish step; the result is held until taken, then the next transaction is accepted.
// Reset (synchronous, active low): all slots free, lists empty, CPU idle, time zero.
`default_nettype none
module tick_driven_task_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [3:0]  in_task_id,
  input  wire logic [7:0]  in_task_priority,
  input  wire logic [7:0]  in_cpu_burst,
  input  wire logic [7:0]  in_io_point_a,
  input  wire logic [7:0]  in_io_len_a,
  input  wire logic [7:0]  in_io_point_b,
  input  wire logic [7:0]  in_io_len_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_tick_time,
  output logic [2:0]       out_event_code,
  output logic [3:0]       out_event_task,
  output logic             out_run_valid,
  output logic [3:0]       out_run_task,
  output logic [15:0]      out_done_wait,
  output logic [15:0]      out_done_turnaround,
  output logic             out_all_finished,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [7:0]  cfg_wdata
);
  import tds_pkg::*;

  state_t state_r, state_nxt;
  logic [2:0] mode_r, mode_nxt;
  logic [7:0] quantum_r, quantum_nxt;
  status_t status_r [MAX_TASKS];
  status_t status_nxt [MAX_TASKS];
  logic [SLOT_W-1:0] rdy_r [MAX_TASKS];
  logic [SLOT_W-1:0] rdy_nxt [MAX_TASKS];
  logic [SLOT_W-1:0] io_r [MAX_TASKS];
  logic [SLOT_W-1:0] io_nxt [MAX_TASKS];
  logic [7:0] key_r [MAX_TASKS];
  logic [7:0] key_nxt [MAX_TASKS];
  logic [MAX_TASKS-1:0] iodone_r, iodone_nxt;
  logic [CNT_W-1:0] rdy_cnt_r, rdy_cnt_nxt, io_cnt_r, io_cnt_nxt;
  logic cur_valid_r, cur_valid_nxt;
  logic [SLOT_W-1:0] cur_task_r, cur_task_nxt;
  logic [7:0] slice_r, slice_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [CNT_W-1:0] walk_cnt_r, walk_cnt_nxt;
  logic pv_r, pv_nxt;
  logic [SLOT_W-1:0] pslot_r, pslot_nxt;
  logic cur_fin_r, cur_fin_nxt, cur_hit_r, cur_hit_nxt;
  logic was_idle_r, was_idle_nxt;
  logic [2:0] ev_r, ev_nxt;
  logic [SLOT_W-1:0] evt_r, evt_nxt;
  logic [15:0] dw_r, dw_nxt, dt_r, dt_nxt;
  logic [CNT_W-1:0] scan_j_r, scan_j_nxt, scan_k_r, scan_k_nxt;
  logic [CNT_W-1:0] scan_i_r, scan_i_nxt;
  logic [SLOT_W-1:0] best_r, best_nxt;
  logic [15:0] otick_r, otick_nxt;
  logic allfin_r, allfin_nxt;

  logic ram_we;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  ent_t ram_wdata, ram_rdata;

  tds_ram #(.WIDTH(ENT_W), .DEPTH(MAX_TASKS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  wire logic by_len  = (mode_r == MODE_SJF) || (mode_r == MODE_SJF_P);
  wire logic preempt = (mode_r == MODE_SJF_P) || (mode_r == MODE_PRIO_P);
  wire logic in_range = 32'(in_task_id) < MAX_TASKS;
  wire logic [SLOT_W-1:0] aid = SLOT_W'(in_task_id);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_req_type == REQ_TICK) state_nxt = S_WALK;
      end
      S_WALK: begin
        if (pv_r && pslot_r == SLOT_W'(MAX_TASKS - 1)) state_nxt = S_POST;
      end
      S_POST: state_nxt = S_IOSCAN;
      S_IOSCAN: begin
        if (scan_j_r >= io_cnt_r) begin
          priority if (mode_r == MODE_FCFS || mode_r == MODE_RR) state_nxt = S_DFIFO;
          else if (mode_r == MODE_SJF || mode_r == MODE_SJF_P || mode_r == MODE_PRIO ||
                   mode_r == MODE_PRIO_P) state_nxt = S_MINSCAN;
          else state_nxt = S_FIN;
        end
      end
      S_DFIFO: state_nxt = (mode_r == MODE_RR) ? S_RREXP : S_FIN;
      S_RREXP: state_nxt = S_FIN;
      S_MINSCAN: begin
        if (scan_i_r >= rdy_cnt_r) state_nxt = S_DPICK;
      end
      S_DPICK: state_nxt = S_FIN;
      S_FIN: state_nxt = S_OUT;
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ent_t e, n;
    logic [7:0] prog, q;
    logic [SLOT_W-1:0] t;
    logic [CNT_W-1:0] last;
    logic is_cur, hit_a, hit_b, fin, pre;

    e = ram_rdata;
    n = ram_rdata;
    prog = '0;
    q = (quantum_r == 8'd0) ? 8'd1 : quantum_r;
    t = '0;
    last = rdy_cnt_r - CNT_W'(1);
    is_cur = 1'b0;
    hit_a = 1'b0;
    hit_b = 1'b0;
    fin = 1'b0;
    pre = 1'b0;

    mode_nxt = mode_r;
    quantum_nxt = quantum_r;
    status_nxt = status_r;
    rdy_nxt = rdy_r;
    io_nxt = io_r;
    key_nxt = key_r;
    iodone_nxt = iodone_r;
    rdy_cnt_nxt = rdy_cnt_r;
    io_cnt_nxt = io_cnt_r;
    cur_valid_nxt = cur_valid_r;
    cur_task_nxt = cur_task_r;
    slice_nxt = slice_r;
    tick_nxt = tick_r;
    walk_cnt_nxt = walk_cnt_r;
    pv_nxt = 1'b0;
    pslot_nxt = pslot_r;
    cur_fin_nxt = cur_fin_r;
    cur_hit_nxt = cur_hit_r;
    was_idle_nxt = was_idle_r;
    ev_nxt = ev_r;
    evt_nxt = evt_r;
    dw_nxt = dw_r;
    dt_nxt = dt_r;
    scan_j_nxt = scan_j_r;
    scan_k_nxt = scan_k_r;
    scan_i_nxt = scan_i_r;
    best_nxt = best_r;
    otick_nxt = otick_r;
    allfin_nxt = allfin_r;
    ram_we = 1'b0;
    ram_waddr = pslot_r;
    ram_wdata = n;
    ram_raddr = walk_cnt_r[SLOT_W-1:0];

    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MODE:    mode_nxt = cfg_wdata[2:0];
        CFG_QUANTUM: quantum_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_req_type == REQ_ARRIVE) begin
          if (in_range && status_r[aid] == ST_FREE) begin
            ram_we = 1'b1;
            ram_waddr = aid;
            ram_wdata = '{left_run: in_cpu_burst, burst: in_cpu_burst,
                          prio: in_task_priority, pt_a: in_io_point_a,
                          len_a: in_io_len_a, pt_b: in_io_point_b, len_b: in_io_len_b,
                          left_io: 8'd0, wait_t: 16'd0, arrive: tick_r};
            status_nxt[aid] = ST_READY;
            if (rdy_cnt_r < CNT_W'(MAX_TASKS)) begin
              rdy_nxt[rdy_cnt_r[SLOT_W-1:0]] = aid;
              rdy_cnt_nxt = rdy_cnt_r + CNT_W'(1);
            end
          end
        end else if (in_valid) begin
          walk_cnt_nxt = '0;
          cur_fin_nxt = 1'b0;
          cur_hit_nxt = 1'b0;
          was_idle_nxt = !cur_valid_r;
          ev_nxt = EV_NONE;
          evt_nxt = '0;
          dw_nxt = '0;
          dt_nxt = '0;
          if (cur_valid_r && slice_r != 8'hFF) slice_nxt = slice_r + 8'd1;
        end
      end
      S_WALK: begin
        if (walk_cnt_r < CNT_W'(MAX_TASKS)) begin
          walk_cnt_nxt = walk_cnt_r + CNT_W'(1);
          pv_nxt = 1'b1;
          pslot_nxt = walk_cnt_r[SLOT_W-1:0];
        end
        if (pv_r) begin
          is_cur = cur_valid_r && cur_task_r == pslot_r;
          if (status_r[pslot_r] == ST_READY && e.wait_t != 16'hFFFF)
            n.wait_t = e.wait_t + 16'd1;
          if (status_r[pslot_r] == ST_IO && e.left_io != 8'd0)
            n.left_io = e.left_io - 8'd1;
          if (is_cur && e.left_run != 8'd0) n.left_run = e.left_run - 8'd1;
          if (is_cur) begin
            fin = n.left_run == 8'd0;
            prog = e.burst - n.left_run;
            hit_a = !fin && e.pt_a != 8'd0 && e.pt_a == prog;
            hit_b = !fin && !hit_a && e.pt_b != 8'd0 && e.pt_b == prog;
            if (hit_a) n.left_io = e.len_a;
            if (hit_b) n.left_io = e.len_b;
            cur_fin_nxt = fin;
            cur_hit_nxt = hit_a || hit_b;
            dw_nxt = e.wait_t;
            dt_nxt = tick_r - e.arrive;
          end
          key_nxt[pslot_r] = by_len ? n.left_run : n.prio;
          iodone_nxt[pslot_r] = (status_r[pslot_r] == ST_IO || hit_a || hit_b) &&
                                n.left_io == 8'd0;
          ram_we = 1'b1;
          ram_waddr = pslot_r;
          ram_wdata = n;
        end
      end
      S_POST: begin
        scan_j_nxt = '0;
        scan_k_nxt = '0;
        if (cur_fin_r) begin
          status_nxt[cur_task_r] = ST_DONE;
          cur_valid_nxt = 1'b0;
          slice_nxt = '0;
          ev_nxt = EV_FINISHED;
          evt_nxt = cur_task_r;
        end else begin
          dw_nxt = '0;
          dt_nxt = '0;
          if (cur_hit_r) begin
            status_nxt[cur_task_r] = ST_IO;
            if (io_cnt_r < CNT_W'(MAX_TASKS)) begin
              io_nxt[io_cnt_r[SLOT_W-1:0]] = cur_task_r;
              io_cnt_nxt = io_cnt_r + CNT_W'(1);
            end
            cur_valid_nxt = 1'b0;
            slice_nxt = '0;
            ev_nxt = EV_TO_IO;
            evt_nxt = cur_task_r;
          end
        end
      end
      S_IOSCAN: begin
        if (scan_j_r < io_cnt_r) begin
          t = io_r[scan_j_r[SLOT_W-1:0]];
          if (iodone_r[t]) begin
            status_nxt[t] = ST_READY;
            if (rdy_cnt_r < CNT_W'(MAX_TASKS)) begin
              rdy_nxt[rdy_cnt_r[SLOT_W-1:0]] = t;
              rdy_cnt_nxt = rdy_cnt_r + CNT_W'(1);
            end
          end else begin
            io_nxt[scan_k_r[SLOT_W-1:0]] = t;
            scan_k_nxt = scan_k_r + CNT_W'(1);
          end
          scan_j_nxt = scan_j_r + CNT_W'(1);
        end else begin
          io_cnt_nxt = scan_k_r;
          scan_i_nxt = CNT_W'(1);
          best_nxt = '0;
        end
      end
      S_DFIFO: begin
        if (!cur_valid_r && rdy_cnt_r != '0) begin
          cur_valid_nxt = 1'b1;
          cur_task_nxt = rdy_r[0];
          status_nxt[rdy_r[0]] = ST_RUN;
          slice_nxt = '0;
          for (int p = 0; p < MAX_TASKS - 1; p++) rdy_nxt[p] = rdy_r[p+1];
          rdy_cnt_nxt = last;
        end
      end
      S_RREXP: begin
        if (cur_valid_r && slice_r >= q) begin
          ev_nxt = EV_EXPIRED;
          evt_nxt = cur_task_r;
          slice_nxt = '0;
          if (rdy_cnt_r == '0) begin
            status_nxt[cur_task_r] = ST_RUN;
          end else begin
            status_nxt[cur_task_r] = ST_READY;
            cur_task_nxt = rdy_r[0];
            status_nxt[rdy_r[0]] = ST_RUN;
            for (int p = 0; p < MAX_TASKS - 1; p++) rdy_nxt[p] = rdy_r[p+1];
            rdy_nxt[last[SLOT_W-1:0]] = cur_task_r;
          end
        end
      end
      S_MINSCAN: begin
        if (scan_i_r < rdy_cnt_r) begin
          if (key_r[rdy_r[scan_i_r[SLOT_W-1:0]]] < key_r[rdy_r[best_r]])
            best_nxt = scan_i_r[SLOT_W-1:0];
          scan_i_nxt = scan_i_r + CNT_W'(1);
        end
      end
      S_DPICK: begin
        pre = preempt && cur_valid_r;
        if (rdy_cnt_r != '0 && (!pre || key_r[rdy_r[best_r]] < key_r[cur_task_r]) &&
            (pre || !cur_valid_r)) begin
          for (int p = 0; p < MAX_TASKS - 1; p++)
            if (p >= int'(best_r)) rdy_nxt[p] = rdy_r[p+1];
          if (pre) begin
            ev_nxt = EV_PREEMPT;
            evt_nxt = cur_task_r;
            status_nxt[cur_task_r] = ST_READY;
            rdy_nxt[last[SLOT_W-1:0]] = cur_task_r;
          end else begin
            rdy_cnt_nxt = last;
          end
          cur_valid_nxt = 1'b1;
          cur_task_nxt = rdy_r[best_r];
          status_nxt[rdy_r[best_r]] = ST_RUN;
          slice_nxt = '0;
        end
      end
      S_FIN: begin
        if (was_idle_r && cur_valid_r) begin
          ev_nxt = EV_IDLE_END;
          evt_nxt = cur_task_r;
        end
        allfin_nxt = 1'b1;
        for (int p = 0; p < MAX_TASKS; p++)
          if (status_r[p] == ST_READY || status_r[p] == ST_RUN || status_r[p] == ST_IO)
            allfin_nxt = 1'b0;
        otick_nxt = tick_r;
        if (tick_r != 16'hFFFF) tick_nxt = tick_r + 16'd1;
      end
      S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r <= MODE_FCFS;
      quantum_r <= 8'd2;
      for (int p = 0; p < MAX_TASKS; p++) status_r[p] <= ST_FREE;
      rdy_cnt_r <= '0;
      io_cnt_r <= '0;
      cur_valid_r <= 1'b0;
      cur_task_r <= '0;
      slice_r <= '0;
      tick_r <= '0;
      walk_cnt_r <= '0;
      pv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r <= mode_nxt;
      quantum_r <= quantum_nxt;
      status_r <= status_nxt;
      rdy_cnt_r <= rdy_cnt_nxt;
      io_cnt_r <= io_cnt_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_task_r <= cur_task_nxt;
      slice_r <= slice_nxt;
      tick_r <= tick_nxt;
      walk_cnt_r <= walk_cnt_nxt;
      pv_r <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rdy_r <= rdy_nxt;
    io_r <= io_nxt;
    key_r <= key_nxt;
    iodone_r <= iodone_nxt;
    pslot_r <= pslot_nxt;
    cur_fin_r <= cur_fin_nxt;
    cur_hit_r <= cur_hit_nxt;
    was_idle_r <= was_idle_nxt;
    ev_r <= ev_nxt;
    evt_r <= evt_nxt;
    dw_r <= dw_nxt;
    dt_r <= dt_nxt;
    scan_j_r <= scan_j_nxt;
    scan_k_r <= scan_k_nxt;
    scan_i_r <= scan_i_nxt;
    best_r <= best_nxt;
    otick_r <= otick_nxt;
    allfin_r <= allfin_nxt;
  end

  assign in_ready = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign out_tick_time = otick_r;
  assign out_event_code = ev_r;
  assign out_event_task = 4'(evt_r);
  assign out_run_valid = cur_valid_r;
  assign out_run_task = cur_valid_r ? 4'(cur_task_r) : 4'd0;
  assign out_done_wait = dw_r;
  assign out_done_turnaround = dt_r;
  assign out_all_finished = allfin_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while result pending");

  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(rdy_cnt_r) + 32'(io_cnt_r)) <= MAX_TASKS) else $error("list overflow");

  a_cur_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && cur_valid_r) |-> status_r[cur_task_r] == ST_RUN)
    else $error("running task not in run state");

  a_walk_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POST) |-> $past(state_r) == S_WALK) else $error("walk skipped");

endmodule
`default_nettype wire
